[rtl/core/sti_pkg.sv]
`timescale 1ns / 1ps

package sti_pkg;

   // field widths fixed by the item format
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // default table depth
   localparam int CAPACITY_DEF = 64;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_DELETED   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

endpackage

[rtl/core/sti_table_ram.sv]
`timescale 1ns / 1ps

// single write port, single registered read port
module sti_table_ram #(
   parameter int DEPTH = sti_pkg::CAPACITY_DEF,
   parameter int AW    = $clog2(sti_pkg::CAPACITY_DEF)
) (
   input  logic                         clock,
   input  logic                         we,
   input  logic [AW-1:0]                waddr,
   input  logic [sti_pkg::VALUE_W-1:0]  wdata,
   input  logic                         re,
   input  logic [AW-1:0]                raddr,
   output logic [sti_pkg::VALUE_W-1:0]  rdata
);

   logic [sti_pkg::VALUE_W-1:0] mem [DEPTH];
   logic [sti_pkg::VALUE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/sti_ctrl.sv]
`timescale 1ns / 1ps

// sequencer: scans the table one entry per read, shifting entries as it goes
module sti_ctrl #(
   parameter int CAPACITY = sti_pkg::CAPACITY_DEF,
   parameter int AW       = $clog2(sti_pkg::CAPACITY_DEF),
   parameter int CW       = $clog2(sti_pkg::CAPACITY_DEF + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  sti_pkg::op_type                     in_op,
   input  logic signed [sti_pkg::VALUE_W-1:0]  in_value,
   output logic                                done_valid,
   input  logic                                done_ready,
   output sti_pkg::status_type                 done_status,
   output logic [CW-1:0]                       done_count,
   output logic                                mem_we,
   output logic [AW-1:0]                       mem_waddr,
   output logic [sti_pkg::VALUE_W-1:0]         mem_wdata,
   output logic                                mem_re,
   output logic [AW-1:0]                       mem_raddr,
   input  logic [sti_pkg::VALUE_W-1:0]         mem_rdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_EVAL,
      S_DONE
   } state_type;

   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   state_type                          state_ff;
   sti_pkg::op_type                    op_ff;
   logic signed [sti_pkg::VALUE_W-1:0] key_ff;
   logic [CW-1:0]                      idx_ff;
   logic [CW-1:0]                      count_ff;
   logic                               found_ff;
   sti_pkg::status_type                status_ff;

   logic [CW-1:0]                      idx_m1;
   logic signed [sti_pkg::VALUE_W-1:0] rd_value;

   assign idx_m1   = idx_ff - 1'b1;
   assign rd_value = $signed(mem_rdata);

   // memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff[AW-1:0];
      mem_wdata = key_ff;
      mem_re    = 1'b0;
      mem_raddr = idx_ff[AW-1:0];
      case (state_ff)
         S_ISSUE: begin
            if (op_ff == sti_pkg::OP_INSERT) begin
               if (idx_ff == '0) begin
                  mem_we = 1'b1;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = idx_m1[AW-1:0];
               end
            end else if (idx_ff != count_ff) begin
               mem_re = 1'b1;
            end
         end
         S_EVAL: begin
            if (op_ff == sti_pkg::OP_INSERT) begin
               mem_we = 1'b1;
               if (rd_value >= key_ff) begin
                  mem_wdata = mem_rdata;
               end
            end else if (found_ff) begin
               mem_we    = 1'b1;
               mem_waddr = idx_m1[AW-1:0];
               mem_wdata = mem_rdata;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  op_ff    <= in_op;
                  key_ff   <= in_value;
                  found_ff <= 1'b0;
                  if (in_op == sti_pkg::OP_INSERT && count_ff == CAP) begin
                     status_ff <= sti_pkg::ST_FULL;
                     state_ff  <= S_DONE;
                  end else begin
                     // insert walks down from the end, delete walks up from 0
                     idx_ff   <= (in_op == sti_pkg::OP_INSERT) ? count_ff : '0;
                     state_ff <= S_ISSUE;
                  end
               end
            end
            S_ISSUE: begin
               if (op_ff == sti_pkg::OP_INSERT) begin
                  if (idx_ff == '0) begin
                     count_ff  <= count_ff + 1'b1;
                     status_ff <= sti_pkg::ST_INSERTED;
                     state_ff  <= S_DONE;
                  end else begin
                     state_ff <= S_EVAL;
                  end
               end else if (idx_ff == count_ff) begin
                  if (found_ff) begin
                     count_ff  <= count_ff - 1'b1;
                     status_ff <= sti_pkg::ST_DELETED;
                  end else begin
                     status_ff <= sti_pkg::ST_NOT_FOUND;
                  end
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               if (op_ff == sti_pkg::OP_INSERT) begin
                  if (rd_value >= key_ff) begin
                     idx_ff   <= idx_m1;
                     state_ff <= S_ISSUE;
                  end else begin
                     count_ff  <= count_ff + 1'b1;
                     status_ff <= sti_pkg::ST_INSERTED;
                     state_ff  <= S_DONE;
                  end
               end else if (found_ff || rd_value < key_ff) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_ISSUE;
               end else if (rd_value == key_ff) begin
                  found_ff <= 1'b1;
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_ISSUE;
               end else begin
                  status_ff <= sti_pkg::ST_NOT_FOUND;
                  state_ff  <= S_DONE;
               end
            end
            S_DONE: begin
               if (done_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign in_ready    = (state_ff == S_IDLE);
   assign done_valid  = (state_ff == S_DONE);
   assign done_status = status_ff;
   assign done_count  = count_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP)
      else $error("entry count above capacity");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ({1'b0, mem_waddr} < (AW+1)'(CAPACITY)))
      else $error("table write beyond capacity");

   a_eval_after_issue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> ($past(state_ff) == S_ISSUE))
      else $error("evaluate without a read issued");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (count_ff == $past(count_ff)
                         || count_ff == $past(count_ff) + 1'b1
                         || count_ff == $past(count_ff) - 1'b1))
      else $error("entry count moved by more than one");
`endif

endmodule

[rtl/core/sorted_table_insert_delete_unit.sv]
`timescale 1ns / 1ps
// timing: a full-table insert goes straight to the response without touching the table; insert
// and delete scan one entry at a time, a read in the issue state, then a compare in the eval state
// throughput: one item at a time
// reset: synchronous, clears entry count and handshake state; table contents are kept
// and never read before written, so no clearing pass is run
module sorted_table_insert_delete_unit #(
   parameter int CAPACITY = sti_pkg::CAPACITY_DEF,
   localparam int AW = $clog2(CAPACITY),
   localparam int CW = $clog2(CAPACITY + 1),
   localparam int DW = ((sti_pkg::STATUS_W + CW + 7) / 8) * 8
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [sti_pkg::VALUE_W-1:0]  req_tdata,   // value
   input  logic [0:0]                   req_tuser,   // opcode
   // response channel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [DW-1:0]                rsp_tdata    // status, entry_count, zero pad
);

   logic                        done_valid;
   logic                        done_ready;
   sti_pkg::status_type         done_status;
   logic [CW-1:0]               done_count;

   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic [sti_pkg::VALUE_W-1:0] mem_wdata;
   logic                        mem_re;
   logic [AW-1:0]               mem_raddr;
   logic [sti_pkg::VALUE_W-1:0] mem_rdata;

   // output register: lets the sequencer take the next item while a response waits
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [DW-1:0]               rsp_data_ff;
   logic [DW-1:0]               rsp_data_in;

   sti_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_op       (sti_pkg::op_type'(req_tuser)),
      .in_value    ($signed(req_tdata)),
      .done_valid  (done_valid),
      .done_ready  (done_ready),
      .done_status (done_status),
      .done_count  (done_count),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_re      (mem_re),
      .mem_raddr   (mem_raddr),
      .mem_rdata   (mem_rdata)
   );

   sti_table_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // register is free when empty or being drained this cycle
   assign done_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done_ready) begin
         rsp_valid_in = done_valid;
         // status in the low bits, count above, zero pad on top
         rsp_data_in  = DW'({done_count, done_status});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
